// ===== design/assert_macros.svh =====
// assert_macros.svh: clocked assertion macros shared by the tone generator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/ttg_pkg.sv =====
// ttg_pkg: constants, codes and beat types of the timed tone generator.
// No dependencies; used by the interface users, the divider and the top level.
`timescale 1ns / 1ps

package ttg_pkg;

	// Defaults for the top-level parameters
	localparam int COUNT_BITS_DEF = 16;
	localparam int PRESCALE_DEF   = 64;

	// Field widths
	localparam int KHZ_W     = 18;
	localparam int FREQ_W    = 16;
	localparam int MS_W      = 16;
	localparam int CYC_W     = 22;
	localparam int CMP_OUT_W = 16;

	// Start checks and scaling
	localparam int FREQ_LOW  = 8;
	localparam int FREQ_HIGH = 16000;
	localparam int MS_PER_S  = 1000;
	localparam int KHZ_RESET = 60000;

	// Serial divider sizing: dividend up to 2^31, divisor up to 32000
	localparam int NUM_W  = 32;
	localparam int DEN_W  = 16;
	localparam int STEP_W = $clog2(NUM_W);

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_STOP  = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RATE,
		ST_QUOT,
		ST_CYC
	} seq_state_t;

	typedef struct packed {
		action_t           action;
		logic [FREQ_W-1:0] freq_hz;
		logic [MS_W-1:0]   duration_ms;
	} in_item_t;

	typedef struct packed {
		logic                 tone_out;
		logic                 playing;
		logic                 finished;
		logic [CMP_OUT_W-1:0] compare_now;
	} out_item_t;

	typedef logic [KHZ_W-1:0] cfg_word_t;

endpackage

// ===== design/ttg_stream_if.sv =====
// ttg_stream_if: valid/ready channel carrying one payload per beat.
// Payload type is a parameter; the types come from ttg_pkg at the user.
`timescale 1ns / 1ps

interface ttg_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/ttg_sdiv.sv =====
// ttg_sdiv: restoring divider, one quotient bit per clock, NUM_W quotient bits a division.
// Depends on ttg_pkg for NUM_W, DEN_W and STEP_W.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttg_sdiv
	import ttg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fits;
	logic              last;

	// one trial subtraction: remainder shifted left with the next dividend bit
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});
	assign last  = (step_q == STEP_W'(NUM_W - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: dividend shifts out at the top, quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;

	`ASSERT_NEVER(a_start_while_busy, clk, arst_n, start && busy_q, "divider restarted mid-run")
	`ASSERT_AT(a_done_follows_run, clk, arst_n, done_q |-> ($past(busy_q) && !busy_q), "done without a finished run")

endmodule

// ===== design/timed_tone_generator.sv =====
// timed_tone_generator: square-wave tone with optional duration, timed by ticks.
// Depends on ttg_pkg, ttg_stream_if and ttg_sdiv (shared bit-serial divider).
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One result beat is returned for every item beat. Stop, tick and unused action
// items are answered in the cycle after the item beat, as is a start whose frequency
// lies outside 8..16000 Hz (it acts as stop). A valid start runs three divisions on
// one restoring divider that yields one quotient bit per clock: prescaled rate,
// half-period compare and half-cycle count, and its result is loaded when the third
// division is done. Items are taken one at a time; a new item is taken while the
// last result is being read out. The timer clock register may be written while
// no start is in progress and is used by the next start.
module timed_tone_generator
	import ttg_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int PRESCALE   = PRESCALE_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ttg_stream_if.sink   item,
	ttg_stream_if.source result,
	ttg_stream_if.sink   cfg
);

	// configuration and tone state
	logic [KHZ_W-1:0]      khz_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] act_cmp_q;
	logic [COUNT_BITS-1:0] pend_cmp_q;
	logic [CYC_W-1:0]      half_q;
	logic                  play_q;
	logic                  pin_q;

	// start sequencer
	seq_state_t            state_q;
	seq_state_t            state_d;
	logic [FREQ_W-1:0]     freq_q;
	logic [MS_W-1:0]       ms_q;
	logic [COUNT_BITS-1:0] new_cmp_q;
	logic [COUNT_BITS-1:0] new_cmp_d;

	// output register
	logic      out_valid_q;
	out_item_t out_data_q;

	// next tone state
	logic [COUNT_BITS-1:0] cnt_d;
	logic [COUNT_BITS-1:0] act_cmp_d;
	logic [COUNT_BITS-1:0] pend_cmp_d;
	logic [CYC_W-1:0]      half_d;
	logic                  play_d;
	logic                  pin_d;
	logic                  fin_d;
	logic                  out_load;

	// divider hookup
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [NUM_W-1:0] div_quot;

	logic                            item_fire;
	logic                            freq_ok;
	logic [NUM_W-1:0]                khz_scaled;
	logic [FREQ_W+MS_W-1:0]          freq_ms;
	logic [NUM_W-1:0]                quot_m1;
	logic [CYC_W-1:0]                cyc_val;
	logic [COUNT_BITS+CMP_OUT_W-1:0] cmp_ext;

	assign item_fire  = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign cfg.ready  = 1'b1;
	assign freq_ok    = (item.data.freq_hz >= FREQ_W'(FREQ_LOW))
		&& (item.data.freq_hz <= FREQ_W'(FREQ_HIGH));
	assign khz_scaled = NUM_W'(khz_q) * NUM_W'(MS_PER_S);
	assign freq_ms    = freq_q * ms_q;
	assign quot_m1    = div_quot - NUM_W'(1);

	// half-period compare: quotient minus one, clamped to the counter range
	always_comb begin
		if (div_quot == '0) begin
			new_cmp_d = '0;
		end else if ((quot_m1 >> COUNT_BITS) != '0) begin
			new_cmp_d = '1;
		end else begin
			new_cmp_d = quot_m1[COUNT_BITS-1:0];
		end
	end

	// half-cycle count: zero stays endless, a timed tone gets at least one
	always_comb begin
		if (ms_q == '0) begin
			cyc_val = '0;
		end else if (div_quot == '0) begin
			cyc_val = CYC_W'(1);
		end else begin
			cyc_val = div_quot[CYC_W-1:0];
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and divider operands
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_fire && (item.data.action == ACT_START) && freq_ok) begin
					div_start = 1'b1;
					div_num   = khz_scaled;
					div_den   = DEN_W'(PRESCALE);
					state_d   = ST_RATE;
				end
			end
			ST_RATE: begin
				if (div_done) begin
					div_start = 1'b1;
					div_num   = div_quot + NUM_W'(freq_q);
					div_den   = DEN_W'({freq_q, 1'b0});
					state_d   = ST_QUOT;
				end
			end
			ST_QUOT: begin
				if (div_done) begin
					div_start = 1'b1;
					div_num   = NUM_W'({freq_ms, 1'b0});
					div_den   = DEN_W'(MS_PER_S);
					state_d   = ST_CYC;
				end
			end
			ST_CYC: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// tone state update for each item, and start completion
	always_comb begin
		cnt_d      = cnt_q;
		act_cmp_d  = act_cmp_q;
		pend_cmp_d = pend_cmp_q;
		half_d     = half_q;
		play_d     = play_q;
		pin_d      = pin_q;
		fin_d      = 1'b0;
		out_load   = 1'b0;
		if (item_fire) begin
			out_load = 1'b1;
			unique case (item.data.action)
				ACT_START: begin
					if (!freq_ok) begin
						play_d = 1'b0;
						pin_d  = 1'b0;
					end else begin
						out_load = 1'b0;
					end
				end
				ACT_STOP: begin
					play_d = 1'b0;
					pin_d  = 1'b0;
				end
				ACT_TICK: begin
					if (play_q) begin
						if (cnt_q == act_cmp_q) begin
							cnt_d     = '0;
							pin_d     = !pin_q;
							act_cmp_d = pend_cmp_q;
							if (half_q != '0) begin
								half_d = half_q - CYC_W'(1);
								if (half_q == CYC_W'(1)) begin
									play_d = 1'b0;
									pin_d  = 1'b0;
									fin_d  = 1'b1;
								end
							end
						end else begin
							cnt_d = cnt_q + COUNT_BITS'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end else if ((state_q == ST_CYC) && div_done) begin
			pend_cmp_d = new_cmp_q;
			half_d     = cyc_val;
			if (!play_q) begin
				act_cmp_d = new_cmp_q;
			end
			play_d   = 1'b1;
			out_load = 1'b1;
		end
	end

	assign cmp_ext = {{CMP_OUT_W{1'b0}}, act_cmp_d};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			khz_q       <= KHZ_W'(KHZ_RESET);
			cnt_q       <= '0;
			act_cmp_q   <= '0;
			pend_cmp_q  <= '0;
			half_q      <= '0;
			play_q      <= 1'b0;
			pin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				khz_q <= cfg.data;
			end
			cnt_q      <= cnt_d;
			act_cmp_q  <= act_cmp_d;
			pend_cmp_q <= pend_cmp_d;
			half_q     <= half_d;
			play_q     <= play_d;
			pin_q      <= pin_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_fire) begin
			freq_q <= item.data.freq_hz;
			ms_q   <= item.data.duration_ms;
		end
		if ((state_q == ST_QUOT) && div_done) begin
			new_cmp_q <= new_cmp_d;
		end
		if (out_load) begin
			out_data_q.tone_out    <= pin_d;
			out_data_q.playing     <= play_d;
			out_data_q.finished    <= fin_d;
			out_data_q.compare_now <= cmp_ext[CMP_OUT_W-1:0];
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	ttg_sdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	`ASSERT_AT(a_pin_low_stopped, clk, arst_n, !play_q |-> !pin_q, "pin high while stopped")
	`ASSERT_AT(a_finish_stops, clk, arst_n, (out_valid_q && out_data_q.finished) |-> (!out_data_q.playing && !out_data_q.tone_out), "finished beat still playing")
	`ASSERT_AT(a_div_done_busy, clk, arst_n, div_done |-> (state_q != ST_IDLE), "divider result with no start in progress")

endmodule
